// File: rtl/ptss_pkg.sv
// Shared types and constants for the periodic task slot scheduler.
`timescale 1ns / 1ps

package ptss_pkg;

    localparam int          MAX_RESULTS = 16;
    localparam int          FIRE_W      = $clog2(MAX_RESULTS + 1);
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] COUNT_WRAP  = 32'hFFFF_FFFE;

    typedef enum logic [2:0] {
        OP_SCAN        = 3'd0,
        OP_REGISTER    = 3'd1,
        OP_UNREGISTER  = 3'd2,
        OP_RESET_COUNT = 3'd3,
        OP_QUERY       = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] now_tick;
        logic [3:0]  slot;
        logic [31:0] period_ticks;
        logic [31:0] first_delay;
        logic [31:0] run_limit;
    } req_t;

    typedef struct packed {
        logic [3:0] out_slot;
        logic       fired;
        logic       was_late;
        logic       flag;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic        active;
        logic [31:0] anchor;
        logic [31:0] delay;
        logic [31:0] period;
        logic [31:0] limit;
        logic [31:0] count;
        logic [31:0] last_tick;
    } slot_rd_t;

    typedef struct packed {
        logic        fire;
        logic        late;
        logic [31:0] next_count;
        logic [31:0] next_tick;
    } slot_eval_t;

endpackage

// File: rtl/ptss_slot_eval.sv
// Firing decision and state update for one task slot during a scan.
`timescale 1ns / 1ps

module ptss_slot_eval
    import ptss_pkg::*;
(
    input  logic [31:0] now_tick,
    input  slot_rd_t    rd,
    input  logic        fire_ok,
    output slot_eval_t  ev
);

    logic [31:0] since_anchor;
    logic [31:0] elapsed;
    logic        due;

    assign since_anchor = now_tick - rd.anchor;
    assign elapsed      = now_tick - rd.last_tick;

    assign due = rd.active
              && (since_anchor >= rd.delay)
              && (rd.count < rd.limit)
              && (elapsed >= rd.period);

    always_comb
    begin
        ev.fire       = due && fire_ok;
        ev.late       = elapsed > rd.period;
        ev.next_tick  = ev.late ? now_tick : (rd.last_tick + rd.period);
        ev.next_count = (rd.count == COUNT_WRAP) ? 32'd0 : (rd.count + 32'd1);
    end

endmodule

// File: rtl/periodic_task_slot_scheduler_core.sv
// Top level of the periodic task slot scheduler.
`timescale 1ns / 1ps

// Register, unregister, reset-count and query requests each give one
// registered result. A scan walks the slot memories one slot per cycle while
// the result side does not stall, and reports the lowest-numbered firing
// slots, at most 16, in slot order, with last set on the final result, or a
// single empty result when nothing fires. One request is in work at a time.
module periodic_task_slot_scheduler_core
    import ptss_pkg::*;
#(
    parameter int SLOT_COUNT = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RW = $clog2(SLOT_COUNT + 1);

    state_t state_reg, state_next;

    logic              out_valid_reg, out_valid_next;
    rsp_t              out_data_reg, out_data_next;
    logic [31:0]       now_reg, now_next;
    logic [RW-1:0]     rd_idx_reg, rd_idx_next;
    logic              ev_valid_reg, ev_valid_next;
    logic [SW-1:0]     ev_idx_reg, ev_idx_next;
    logic [FIRE_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [3:0]        pend_slot_reg, pend_slot_next;
    logic              pend_late_reg, pend_late_next;
    logic [SLOT_COUNT-1:0] active_reg, active_next;
    logic [SLOT_COUNT-1:0] dyn_vld_reg, dyn_vld_next;

    logic [127:0] stat_mem [SLOT_COUNT];
    logic [63:0]  dyn_mem  [SLOT_COUNT];
    logic [127:0] stat_rd;
    logic [63:0]  dyn_rd;

    logic          out_can_load;
    logic          take;
    logic          slot_ok;
    logic [SW-1:0] req_idx;
    logic          rd_en;
    logic          stat_we;
    logic          dyn_we_cnt;
    logic          dyn_we_tick;
    logic [SW-1:0] dyn_waddr;
    logic [31:0]   dyn_wcnt;
    logic [31:0]   dyn_wtick;
    logic          hold;
    logic          scan_end;
    slot_rd_t      slot_rd;
    slot_eval_t    ev;

    assign out_can_load = !out_valid_reg || !rsp_stall;
    assign take         = req_valid && !req_stall;
    assign slot_ok      = 32'(req.slot) < SLOT_COUNT;
    assign req_idx      = SW'(req.slot);
    assign scan_end     = (rd_idx_reg == RW'(SLOT_COUNT)) && !ev_valid_reg;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[req_idx] <= {req.now_tick, req.first_delay,
                                  (req.period_ticks == 32'd0) ? 32'd1 : req.period_ticks,
                                  req.run_limit};
        end
        if (rd_en)
        begin
            stat_rd <= stat_mem[SW'(rd_idx_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dyn_we_cnt)
        begin
            dyn_mem[dyn_waddr][63:32] <= dyn_wcnt;
        end
        if (dyn_we_tick)
        begin
            dyn_mem[dyn_waddr][31:0] <= dyn_wtick;
        end
        if (rd_en)
        begin
            dyn_rd <= dyn_mem[SW'(rd_idx_reg)];
        end
    end

    always_comb
    begin
        slot_rd.active    = active_reg[ev_idx_reg];
        slot_rd.anchor    = stat_rd[127:96];
        slot_rd.delay     = stat_rd[95:64];
        slot_rd.period    = stat_rd[63:32];
        slot_rd.limit     = stat_rd[31:0];
        slot_rd.count     = dyn_vld_reg[ev_idx_reg] ? dyn_rd[63:32] : 32'd0;
        slot_rd.last_tick = dyn_vld_reg[ev_idx_reg] ? dyn_rd[31:0] : 32'd0;
    end

    ptss_slot_eval u_eval (
        .now_tick (now_reg),
        .rd       (slot_rd),
        .fire_ok  (fire_cnt_reg < FIRE_W'(MAX_RESULTS)),
        .ev       (ev)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && (opcode_t'(req.opcode) == OP_SCAN))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && rsp_stall;
        out_data_next   = out_data_reg;
        now_next        = now_reg;
        rd_idx_next     = rd_idx_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        fire_cnt_next   = fire_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_late_next  = pend_late_reg;
        active_next     = active_reg;
        dyn_vld_next    = dyn_vld_reg;
        req_stall       = 1'b1;
        rd_en           = 1'b0;
        stat_we         = 1'b0;
        dyn_we_cnt      = 1'b0;
        dyn_we_tick     = 1'b0;
        dyn_waddr       = ev_idx_reg;
        dyn_wcnt        = 32'd0;
        dyn_wtick       = 32'd0;
        hold            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = !out_can_load;
                if (take)
                begin
                    if (opcode_t'(req.opcode) == OP_SCAN)
                    begin
                        now_next        = req.now_tick;
                        rd_idx_next     = '0;
                        ev_valid_next   = 1'b0;
                        fire_cnt_next   = '0;
                        pend_valid_next = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{req.slot, 1'b0, 1'b0, 1'b0, 1'b1};
                        if (slot_ok)
                        begin
                            unique case (opcode_t'(req.opcode))
                                OP_REGISTER:
                                begin
                                    stat_we              = 1'b1;
                                    active_next[req_idx] = 1'b1;
                                    out_data_next.flag   = 1'b1;
                                end
                                OP_UNREGISTER:
                                begin
                                    if (active_reg[req_idx])
                                    begin
                                        active_next[req_idx]  = 1'b0;
                                        out_data_next.flag    = 1'b1;
                                        dyn_waddr             = req_idx;
                                        dyn_we_cnt            = 1'b1;
                                        dyn_we_tick           = !dyn_vld_reg[req_idx];
                                        dyn_vld_next[req_idx] = 1'b1;
                                    end
                                end
                                OP_RESET_COUNT:
                                begin
                                    dyn_waddr             = req_idx;
                                    dyn_we_cnt            = 1'b1;
                                    dyn_we_tick           = !dyn_vld_reg[req_idx];
                                    dyn_vld_next[req_idx] = 1'b1;
                                end
                                OP_QUERY:
                                begin
                                    out_data_next.flag = active_reg[req_idx];
                                end
                                default:
                                begin
                                    out_data_next.flag = 1'b0;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                hold = ev_valid_reg && ev.fire && pend_valid_reg && !out_can_load;
                if (!hold)
                begin
                    if (ev_valid_reg && ev.fire)
                    begin
                        dyn_waddr  = ev_idx_reg;
                        dyn_we_cnt  = 1'b1;
                        dyn_we_tick = 1'b1;
                        dyn_wcnt    = ev.next_count;
                        dyn_wtick   = ev.next_tick;
                        dyn_vld_next[ev_idx_reg] = 1'b1;
                        fire_cnt_next = fire_cnt_reg + FIRE_W'(1);
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '{pend_slot_reg, 1'b1, pend_late_reg, 1'b0, 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = 4'(ev_idx_reg);
                        pend_late_next  = ev.late;
                    end
                    if (rd_idx_reg < RW'(SLOT_COUNT))
                    begin
                        rd_en         = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = SW'(rd_idx_reg);
                        rd_idx_next   = rd_idx_reg + RW'(1);
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_can_load)
                begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_data_next = '{pend_slot_reg, 1'b1, pend_late_reg, 1'b0, 1'b1};
                    end
                    else
                    begin
                        out_data_next = '{4'd0, 1'b0, 1'b0, 1'b0, 1'b1};
                    end
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            rd_idx_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            active_reg     <= '0;
            dyn_vld_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            rd_idx_reg     <= rd_idx_next;
            ev_valid_reg   <= ev_valid_next;
            fire_cnt_reg   <= fire_cnt_next;
            pend_valid_reg <= pend_valid_next;
            active_reg     <= active_next;
            dyn_vld_reg    <= dyn_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        now_reg       <= now_next;
        ev_idx_reg    <= ev_idx_next;
        pend_slot_reg <= pend_slot_next;
        pend_late_reg <= pend_late_next;
    end

endmodule
